[rtl/cwsg_pkg.sv]
// Shared constants, types and the quarter-wave sine table builder for the curlicue walk.
package cwsg_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int POS_FRAC_BITS   = 16;
    localparam int COUNT_BITS      = 24;

    localparam int POS_BITS        = 40;
    localparam int ZOOM_BITS       = 32;
    localparam int ZOOM_FRAC_BITS  = 16;
    localparam int SCREEN_BITS     = 16;
    localparam int LIMIT_BITS      = 24;
    localparam int STEP_BITS       = 32;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 32;
    localparam int IN_TDATA_BITS   = 8;
    localparam int OUT_TDATA_BITS  = 4 * SCREEN_BITS;

    localparam int TBL_N           = 1 << SINE_TABLE_BITS;
    localparam int ADDR_BITS       = SINE_TABLE_BITS + 1;
    localparam int ENTRY_BITS      = POS_FRAC_BITS + 1;
    localparam int SINE_BITS       = POS_FRAC_BITS + 2;
    localparam int SCREEN_STAGES   = 4;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // reciprocals ceil(2^43 / (2n(2n+1))), exact floor division for terms below 2^34
    localparam int          TAYLOR_SHIFT = 43;
    localparam logic [63:0] RECIP_6   = 64'(((128'd1 << TAYLOR_SHIFT) + 128'd5) / 128'd6);
    localparam logic [63:0] RECIP_20  = 64'(((128'd1 << TAYLOR_SHIFT) + 128'd19) / 128'd20);
    localparam logic [63:0] RECIP_42  = 64'(((128'd1 << TAYLOR_SHIFT) + 128'd41) / 128'd42);
    localparam logic [63:0] RECIP_72  = 64'(((128'd1 << TAYLOR_SHIFT) + 128'd71) / 128'd72);
    localparam logic [63:0] RECIP_110 = 64'(((128'd1 << TAYLOR_SHIFT) + 128'd109) / 128'd110);
    localparam logic [63:0] RECIP_156 = 64'(((128'd1 << TAYLOR_SHIFT) + 128'd155) / 128'd156);
    localparam logic [63:0] RECIP_210 = 64'(((128'd1 << TAYLOR_SHIFT) + 128'd209) / 128'd210);
    localparam logic [63:0] RECIP_272 = 64'(((128'd1 << TAYLOR_SHIFT) + 128'd271) / 128'd272);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ZOOM       = 3'd0,
        CFG_CENTRE_X   = 3'd1,
        CFG_CENTRE_Y   = 3'd2,
        CFG_PHASE_STEP = 3'd3,
        CFG_ITER_LIMIT = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic valid;
        logic seg_valid;
        logic last;
        logic restart;
    } t_seg_ctl;

    typedef logic [TBL_N:0][ENTRY_BITS-1:0] t_sine_rom;

    // term / (2n(2n+1)) truncated, by reciprocal multiplication
    function automatic logic [63:0] taylor_div(logic [63:0] term, int n);
        logic [63:0]  m;
        logic [127:0] p;
        case (n)
            1:       m = RECIP_6;
            2:       m = RECIP_20;
            3:       m = RECIP_42;
            4:       m = RECIP_72;
            5:       m = RECIP_110;
            6:       m = RECIP_156;
            7:       m = RECIP_210;
            default: m = RECIP_272;
        endcase
        p = (128'(term) * 128'(m)) >> TAYLOR_SHIFT;
        return p[63:0];
    endfunction

    // sin over a quarter turn, Q30 Taylor series to x^17, rounded to POS_FRAC_BITS
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom          rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        for (int k = 0; k <= TBL_N; k++) begin
            x    = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            for (int n = 1; n <= 8; n++) begin
                term = (term * x2) >> 30;
                term = taylor_div(term, n);
                if (n % 2 == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            r = (sum + (64'sd1 <<< (29 - POS_FRAC_BITS))) >>> (30 - POS_FRAC_BITS);
            if (r > (64'sd1 <<< POS_FRAC_BITS)) begin
                r = 64'sd1 <<< POS_FRAC_BITS;
            end
            rom[k] = r[ENTRY_BITS-1:0];
        end
        return rom;
    endfunction

endpackage

[rtl/curlicue_walk_segment_generator.sv]
// Top level of the curlicue walk segment generator: config registers and pipeline control.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata[0] restart
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata start/end x,y; tuser valid; tlast
//  cfg       in   i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// One segment per cycle while the output is not stalled; an accepted transaction passes through the
// heading register, ROM read, position add, then four screen-mapping stages
// (abs, split 20x32 multiplies, product sum, centre and saturate).
// Reset is synchronous and clears angles, count, position and pipeline valids.
// A stalled output holds the whole pipeline, empty stages included, and drops s_axis_tready.
module curlicue_walk_segment_generator (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  logic [cwsg_pkg::IN_TDATA_BITS-1:0]       s_axis_tdata,  // [0] restart
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    output logic [cwsg_pkg::OUT_TDATA_BITS-1:0]      m_axis_tdata,  // start_x, start_y, end_x, end_y
    output logic [0:0]                               m_axis_tuser,  // [0] segment_valid
    output logic                                     m_axis_tlast,  // last_segment
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [cwsg_pkg::CFG_INDEX_BITS-1:0]      i_cfg_index,
    input  logic [cwsg_pkg::CFG_DATA_BITS-1:0]       i_cfg_data
);
    import cwsg_pkg::*;

    logic [ZOOM_BITS-1:0]          r_zoom;
    logic signed [SCREEN_BITS-1:0] r_centre_x;
    logic signed [SCREEN_BITS-1:0] r_centre_y;
    logic [STEP_BITS-1:0]          r_phase_step;
    logic [LIMIT_BITS-1:0]         r_limit;
    t_seg_ctl                      r_ctl_pipe [SCREEN_STAGES];

    logic                          adv;
    logic                          take;
    t_seg_ctl                      w_ctl_h, w_ctl_r, w_ctl_p;
    logic [PHASE_BITS-1:0]         w_heading;
    logic signed [SINE_BITS-1:0]   w_cos, w_sin;
    logic signed [POS_BITS-1:0]    w_x0, w_y0, w_x1, w_y1;
    logic signed [SCREEN_BITS-1:0] w_sx0, w_sy0, w_sx1, w_sy1;
    t_seg_ctl                      out_ctl;

    assign out_ctl       = r_ctl_pipe[SCREEN_STAGES-1];
    assign adv           = !out_ctl.valid || m_axis_tready;
    assign take          = s_axis_tvalid && adv;
    assign s_axis_tready = adv;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom       <= ZOOM_BITS'(65536);
            r_centre_x   <= '0;
            r_centre_y   <= '0;
            r_phase_step <= STEP_BITS'(660174260);
            r_limit      <= LIMIT_BITS'(1000);
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ZOOM:       r_zoom       <= i_cfg_data[ZOOM_BITS-1:0];
                CFG_CENTRE_X:   r_centre_x   <= i_cfg_data[SCREEN_BITS-1:0];
                CFG_CENTRE_Y:   r_centre_y   <= i_cfg_data[SCREEN_BITS-1:0];
                CFG_PHASE_STEP: r_phase_step <= i_cfg_data[STEP_BITS-1:0];
                CFG_ITER_LIMIT: r_limit      <= i_cfg_data[LIMIT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    cwsg_heading u_heading (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_adv        (adv),
        .i_restart    (s_axis_tdata[0]),
        .i_phase_step (r_phase_step),
        .i_limit      (r_limit),
        .o_ctl        (w_ctl_h),
        .o_heading    (w_heading)
    );

    cwsg_sine_rom u_rom (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_ctl     (w_ctl_h),
        .i_heading (w_heading),
        .o_ctl     (w_ctl_r),
        .o_cos     (w_cos),
        .o_sin     (w_sin)
    );

    cwsg_position u_position (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ctl   (w_ctl_r),
        .i_cos   (w_cos),
        .i_sin   (w_sin),
        .o_ctl   (w_ctl_p),
        .o_x0    (w_x0),
        .o_y0    (w_y0),
        .o_x1    (w_x1),
        .o_y1    (w_y1)
    );

    cwsg_screen_map u_map_x0 (
        .i_clk (i_clk), .i_adv (adv), .i_p (w_x0), .i_negate (1'b0),
        .i_zoom (r_zoom), .i_centre (r_centre_x), .o_coord (w_sx0)
    );

    cwsg_screen_map u_map_y0 (
        .i_clk (i_clk), .i_adv (adv), .i_p (w_y0), .i_negate (1'b1),
        .i_zoom (r_zoom), .i_centre (r_centre_y), .o_coord (w_sy0)
    );

    cwsg_screen_map u_map_x1 (
        .i_clk (i_clk), .i_adv (adv), .i_p (w_x1), .i_negate (1'b0),
        .i_zoom (r_zoom), .i_centre (r_centre_x), .o_coord (w_sx1)
    );

    cwsg_screen_map u_map_y1 (
        .i_clk (i_clk), .i_adv (adv), .i_p (w_y1), .i_negate (1'b1),
        .i_zoom (r_zoom), .i_centre (r_centre_y), .o_coord (w_sy1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SCREEN_STAGES; i++) begin
                r_ctl_pipe[i] <= '0;
            end
        end else if (adv) begin
            r_ctl_pipe[0] <= w_ctl_p;
            for (int i = 1; i < SCREEN_STAGES; i++) begin
                r_ctl_pipe[i] <= r_ctl_pipe[i-1];
            end
        end
    end

    // finished walk reports zero coordinates
    assign m_axis_tvalid = out_ctl.valid;
    assign m_axis_tuser  = out_ctl.seg_valid;
    assign m_axis_tlast  = out_ctl.last;
    assign m_axis_tdata  = out_ctl.seg_valid ? {w_sy1, w_sx1, w_sy0, w_sx0} : '0;

    a_accept_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> w_ctl_h.valid)
        else $error("accepted transaction did not enter the pipeline");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no pending result");

    a_last_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
        else $error("last segment flagged on a finished walk");

    a_stall_freezes_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(w_ctl_p) && $stable(w_ctl_r))
        else $error("pipeline moved during output stall");

    a_restart_has_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[0] && (r_limit != '0)
        |=> w_ctl_h.seg_valid)
        else $error("restart with nonzero limit gave no segment");

endmodule

[rtl/cwsg_heading.sv]
// Angle and segment count recurrence; issues one heading per accepted transaction.
module cwsg_heading (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_take,
    input  logic                            i_adv,
    input  logic                            i_restart,
    input  logic [cwsg_pkg::STEP_BITS-1:0]  i_phase_step,
    input  logic [cwsg_pkg::LIMIT_BITS-1:0] i_limit,
    output cwsg_pkg::t_seg_ctl              o_ctl,
    output logic [cwsg_pkg::PHASE_BITS-1:0] o_heading
);
    import cwsg_pkg::*;

    localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

    logic [PHASE_BITS-1:0] r_heading, n_heading;
    logic [PHASE_BITS-1:0] r_turn, n_turn;
    logic [COUNT_BITS-1:0] r_count, n_count;
    t_seg_ctl              r_ctl;
    logic [PHASE_BITS-1:0] r_out_heading;

    logic [PHASE_BITS-1:0] cur_heading;
    logic [PHASE_BITS-1:0] cur_turn;
    logic [COUNT_BITS-1:0] cur_count;
    logic [31:0]           lim_ext;
    logic [31:0]           eff_limit;
    logic [31:0]           count_ext;
    logic                  seg_ok;
    logic                  seg_last;

    always_comb begin
        cur_heading = i_restart ? '0 : r_heading;
        cur_turn    = i_restart ? '0 : r_turn;
        cur_count   = i_restart ? '0 : r_count;
        lim_ext     = 32'(i_limit);
        eff_limit   = (lim_ext > COUNT_MAX) ? COUNT_MAX : lim_ext;
        count_ext   = 32'(cur_count);
        seg_ok      = count_ext < eff_limit;
        seg_last    = (count_ext + 32'd1) == eff_limit;

        n_heading = r_heading;
        n_turn    = r_turn;
        n_count   = r_count;
        if (i_take) begin
            n_heading = cur_heading;
            n_turn    = cur_turn;
            n_count   = cur_count;
            if (seg_ok) begin
                n_heading = cur_heading + cur_turn;
                n_turn    = cur_turn + i_phase_step[STEP_BITS-1 -: PHASE_BITS];
                n_count   = cur_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= '0;
            r_turn    <= '0;
            r_count   <= '0;
            r_ctl     <= '0;
        end else begin
            r_heading <= n_heading;
            r_turn    <= n_turn;
            r_count   <= n_count;
            if (i_adv) begin
                r_ctl.valid     <= i_take;
                r_ctl.seg_valid <= i_take & seg_ok;
                r_ctl.last      <= i_take & seg_ok & seg_last;
                r_ctl.restart   <= i_take & i_restart;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_out_heading <= cur_heading;
        end
    end

    assign o_ctl     = r_ctl;
    assign o_heading = r_out_heading;

endmodule

[rtl/cwsg_sine_rom.sv]
// Quarter-wave sine ROM with two registered reads for cosine and sine of the heading.
module cwsg_sine_rom (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_adv,
    input  cwsg_pkg::t_seg_ctl                     i_ctl,
    input  logic [cwsg_pkg::PHASE_BITS-1:0]        i_heading,
    output cwsg_pkg::t_seg_ctl                     o_ctl,
    output logic signed [cwsg_pkg::SINE_BITS-1:0]  o_cos,
    output logic signed [cwsg_pkg::SINE_BITS-1:0]  o_sin
);
    import cwsg_pkg::*;

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    logic [SINE_TABLE_BITS+1:0] top;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                 quad_s;
    logic [1:0]                 quad_c;
    logic [ADDR_BITS-1:0]       addr_s;
    logic [ADDR_BITS-1:0]       addr_c;

    t_seg_ctl              r_ctl;
    logic [ENTRY_BITS-1:0] r_cos_entry;
    logic [ENTRY_BITS-1:0] r_sin_entry;
    logic                  r_cos_neg;
    logic                  r_sin_neg;

    always_comb begin
        top    = i_heading[PHASE_BITS-1 -: SINE_TABLE_BITS+2];
        idx    = top[SINE_TABLE_BITS-1:0];
        quad_s = top[SINE_TABLE_BITS+1:SINE_TABLE_BITS];
        quad_c = quad_s + 2'd1;
        addr_s = quad_s[0] ? (ADDR_BITS'(TBL_N) - {1'b0, idx}) : {1'b0, idx};
        addr_c = quad_c[0] ? (ADDR_BITS'(TBL_N) - {1'b0, idx}) : {1'b0, idx};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cos_entry <= SINE_ROM[addr_c];
            r_sin_entry <= SINE_ROM[addr_s];
            r_cos_neg   <= quad_c[1];
            r_sin_neg   <= quad_s[1];
        end
    end

    assign o_ctl = r_ctl;
    assign o_cos = r_cos_neg ? -signed'({1'b0, r_cos_entry}) : signed'({1'b0, r_cos_entry});
    assign o_sin = r_sin_neg ? -signed'({1'b0, r_sin_entry}) : signed'({1'b0, r_sin_entry});

endmodule

[rtl/cwsg_position.sv]
// Walk position accumulator; registers both segment endpoints.
module cwsg_position (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_adv,
    input  cwsg_pkg::t_seg_ctl                    i_ctl,
    input  logic signed [cwsg_pkg::SINE_BITS-1:0] i_cos,
    input  logic signed [cwsg_pkg::SINE_BITS-1:0] i_sin,
    output cwsg_pkg::t_seg_ctl                    o_ctl,
    output logic signed [cwsg_pkg::POS_BITS-1:0]  o_x0,
    output logic signed [cwsg_pkg::POS_BITS-1:0]  o_y0,
    output logic signed [cwsg_pkg::POS_BITS-1:0]  o_x1,
    output logic signed [cwsg_pkg::POS_BITS-1:0]  o_y1
);
    import cwsg_pkg::*;

    logic signed [POS_BITS-1:0] r_pos_x, n_pos_x;
    logic signed [POS_BITS-1:0] r_pos_y, n_pos_y;
    t_seg_ctl                   r_ctl;
    logic signed [POS_BITS-1:0] r_x0, r_y0, r_x1, r_y1;

    logic signed [POS_BITS-1:0] x0, y0, x1, y1;

    always_comb begin
        x0 = i_ctl.restart ? '0 : r_pos_x;
        y0 = i_ctl.restart ? '0 : r_pos_y;
        x1 = x0 + POS_BITS'(i_cos);
        y1 = y0 + POS_BITS'(i_sin);

        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        if (i_adv && i_ctl.valid) begin
            n_pos_x = i_ctl.seg_valid ? x1 : x0;
            n_pos_y = i_ctl.seg_valid ? y1 : y0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_ctl   <= '0;
        end else begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            if (i_adv) begin
                r_ctl <= i_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x0 <= x0;
            r_y0 <= y0;
            r_x1 <= x1;
            r_y1 <= y1;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x0  = r_x0;
    assign o_y0  = r_y0;
    assign o_x1  = r_x1;
    assign o_y1  = r_y1;

endmodule

[rtl/cwsg_screen_map.sv]
// Four-stage zoom, centre offset, truncation and saturation of one walk coordinate.
module cwsg_screen_map (
    input  logic                                    i_clk,
    input  logic                                    i_adv,
    input  logic signed [cwsg_pkg::POS_BITS-1:0]    i_p,
    input  logic                                    i_negate,
    input  logic [cwsg_pkg::ZOOM_BITS-1:0]          i_zoom,
    input  logic signed [cwsg_pkg::SCREEN_BITS-1:0] i_centre,
    output logic signed [cwsg_pkg::SCREEN_BITS-1:0] o_coord
);
    import cwsg_pkg::*;

    localparam int MAG_SPLIT = POS_BITS / 2;
    localparam int LO_BITS   = MAG_SPLIT + ZOOM_BITS;
    localparam int HI_BITS   = (POS_BITS - MAG_SPLIT) + ZOOM_BITS;
    localparam int PROD_BITS = POS_BITS + ZOOM_BITS;
    localparam int QSHIFT    = ZOOM_FRAC_BITS + POS_FRAC_BITS;
    localparam int Q_BITS    = PROD_BITS - QSHIFT;
    localparam int V_BITS    = Q_BITS + 2;
    localparam logic signed [V_BITS-1:0] SAT_MAX = V_BITS'(32767);
    localparam logic signed [V_BITS-1:0] SAT_MIN = -V_BITS'(32768);

    logic [POS_BITS-1:0]   r_mag;
    logic                  r_neg1;
    logic [LO_BITS-1:0]    r_pp_lo;
    logic [HI_BITS-1:0]    r_pp_hi;
    logic                  r_neg2;
    logic [Q_BITS-1:0]     r_q;
    logic                  r_frac;
    logic                  r_neg3;
    logic signed [SCREEN_BITS-1:0] r_coord;

    logic [POS_BITS-1:0]    mag;
    logic [PROD_BITS-1:0]   prod;
    logic signed [V_BITS-1:0] q_ext;
    logic signed [V_BITS-1:0] v;

    always_comb begin
        mag  = i_p[POS_BITS-1] ? (~i_p + 1'b1) : i_p;
        prod = (PROD_BITS'(r_pp_hi) << MAG_SPLIT) + PROD_BITS'(r_pp_lo);
        q_ext = signed'(V_BITS'(r_q));
        if (r_neg3) begin
            v = V_BITS'(i_centre) - q_ext;
            if (v > 0 && r_frac) begin
                v = v - 1'b1;
            end
        end else begin
            v = V_BITS'(i_centre) + q_ext;
            if (v < 0 && r_frac) begin
                v = v + 1'b1;
            end
        end
        if (v > SAT_MAX) begin
            v = SAT_MAX;
        end
        if (v < SAT_MIN) begin
            v = SAT_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mag   <= mag;
            r_neg1  <= i_p[POS_BITS-1] ^ i_negate;
            r_pp_lo <= LO_BITS'(r_mag[MAG_SPLIT-1:0]) * LO_BITS'(i_zoom);
            r_pp_hi <= HI_BITS'(r_mag[POS_BITS-1:MAG_SPLIT]) * HI_BITS'(i_zoom);
            r_neg2  <= r_neg1;
            r_q     <= prod[PROD_BITS-1:QSHIFT];
            r_frac  <= |prod[QSHIFT-1:0];
            r_neg3  <= r_neg2;
            r_coord <= v[SCREEN_BITS-1:0];
        end
    end

    assign o_coord = r_coord;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the curlicue walk segment generator.
`timescale 1ns / 100ps

module tb_top;
    import cwsg_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int END_WAIT    = 20;
    localparam int TABLE_LEN   = 1 << SINE_TABLE_BITS;
    localparam logic [7:0] FIRST_RESTARTS = 8'b0010_0001;

    typedef struct {
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] ex;
        logic [15:0] ey;
        logic        vld;
        logic        lst;
    } t_segment;

    class segment_checker;
        logic [31:0]        zoom;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [31:0]        phase_step;
        logic [23:0]        iter_limit;
        logic [31:0]        turn_rate;
        logic [31:0]        heading;
        logic [39:0]        pos_x;
        logic [39:0]        pos_y;
        logic [23:0]        steps;
        logic [16:0]        quarter_sine [0:TABLE_LEN];
        t_segment           segments_due [$];
        int                 errors;

        function new();
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint          sum;
            longint          r;
            for (int k = 0; k <= TABLE_LEN; k++) begin
                x    = (64'(k) * 64'd1686629713) / 64'(TABLE_LEN);
                x2   = (x * x) >> 30;
                term = x;
                sum  = longint'(x);
                for (int n = 1; n <= 8; n++) begin
                    term = (term * x2) >> 30;
                    term = term / 64'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) begin
                        sum = sum - longint'(term);
                    end else begin
                        sum = sum + longint'(term);
                    end
                end
                if (sum < 0) begin
                    sum = 0;
                end
                r = (sum + (64'sd1 <<< (29 - POS_FRAC_BITS))) >>> (30 - POS_FRAC_BITS);
                if (r > (64'sd1 <<< POS_FRAC_BITS)) begin
                    r = 64'sd1 <<< POS_FRAC_BITS;
                end
                quarter_sine[k] = r[16:0];
            end
            zoom       = 32'd65536;
            cx         = '0;
            cy         = '0;
            phase_step = 32'd660174260;
            iter_limit = 24'd1000;
            turn_rate  = '0;
            heading    = '0;
            pos_x      = '0;
            pos_y      = '0;
            steps      = '0;
            errors     = 0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [31:0] d);
            case (idx)
                CFG_ZOOM:       zoom       = d;
                CFG_CENTRE_X:   cx         = d[15:0];
                CFG_CENTRE_Y:   cy         = d[15:0];
                CFG_PHASE_STEP: phase_step = d;
                CFG_ITER_LIMIT: iter_limit = d[23:0];
                default: ;
            endcase
        endfunction

        // sine of angle advanced by off quarter turns
        function longint sine_at(logic [31:0] ang, logic [1:0] off);
            logic [11:0] top;
            logic [1:0]  quad;
            int          idx;
            longint      v;
            top  = ang[31:20];
            idx  = int'(top[9:0]);
            quad = top[11:10] + off;
            v    = quad[0] ? longint'(quarter_sine[TABLE_LEN - idx])
                           : longint'(quarter_sine[idx]);
            return quad[1] ? -v : v;
        endfunction

        function logic [15:0] to_pixel(longint p, bit flip, logic signed [15:0] ctr);
            bit              neg;
            bit              frac;
            longint unsigned mag;
            longint unsigned lo;
            longint unsigned hi;
            longint unsigned mid;
            longint          q;
            longint          v;
            neg  = (p < 0) != flip;
            mag  = (p < 0) ? -p : p;
            lo   = mag * 64'(zoom[15:0]);
            hi   = mag * 64'(zoom[31:16]);
            mid  = hi + (lo >> 16);
            q    = longint'(mid >> POS_FRAC_BITS);
            frac = (lo[15:0] != 0) || (mid[POS_FRAC_BITS-1:0] != 0);
            if (!neg) begin
                v = q + ctr;
                if (v < 0 && frac) v = v + 1;
            end else begin
                v = ctr - q;
                if (v > 0 && frac) v = v - 1;
            end
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
        endfunction

        function void note_step(bit restart);
            t_segment s;
            longint   x0;
            longint   y0;
            longint   x1;
            longint   y1;
            if (restart) begin
                turn_rate = '0;
                heading   = '0;
                pos_x     = '0;
                pos_y     = '0;
                steps     = '0;
            end
            if (steps >= iter_limit) begin
                s = '{default: '0};
            end else begin
                x0    = longint'($signed(pos_x));
                y0    = longint'($signed(pos_y));
                x1    = longint'($signed(40'(x0 + sine_at(heading, 2'd1))));
                y1    = longint'($signed(40'(y0 + sine_at(heading, 2'd0))));
                s.sx  = to_pixel(x0, 1'b0, cx);
                s.sy  = to_pixel(y0, 1'b1, cy);
                s.ex  = to_pixel(x1, 1'b0, cx);
                s.ey  = to_pixel(y1, 1'b1, cy);
                s.vld = 1'b1;
                s.lst = (25'(steps) + 25'd1) == 25'(iter_limit);
                pos_x     = 40'(x1);
                pos_y     = 40'(y1);
                heading   = heading + turn_rate;
                turn_rate = turn_rate + phase_step;
                steps     = steps + 24'd1;
            end
            segments_due.push_back(s);
        endfunction

        function void compare(string name, logic [15:0] e, logic [15:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t MISMATCH %s expected %0d actual %0d",
                         $time, name, $signed(e), $signed(a));
            end
        endfunction

        function void check_segment(logic [63:0] d, logic u, logic l);
            t_segment e;
            if (segments_due.size() == 0) begin
                errors++;
                $display("%0t MISMATCH unexpected segment expected none actual %h",
                         $time, d);
                return;
            end
            e = segments_due.pop_front();
            compare("start_x", e.sx, d[15:0]);
            compare("start_y", e.sy, d[31:16]);
            compare("end_x", e.ex, d[47:32]);
            compare("end_y", e.ey, d[63:48]);
            compare("segment_valid", 16'(e.vld), 16'(u));
            compare("last_segment", 16'(e.lst), 16'(l));
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [IN_TDATA_BITS-1:0]      s_axis_tdata;   // [0] restart, rest zero
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [OUT_TDATA_BITS-1:0]     m_axis_tdata;   // start_x, start_y, end_x, end_y
    logic [0:0]                    m_axis_tuser;   // [0] segment_valid
    logic                          m_axis_tlast;   // last_segment
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     i_cfg_index;
    logic [CFG_DATA_BITS-1:0]      i_cfg_data;

    segment_checker sb;
    int             tx_mode;
    int             rx_mode;
    int             rx_hold;
    int             quiet;

    curlicue_walk_segment_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // 0: never idle, 1: 0..15 every time, 2: occasional
    function automatic int draw_wait(int mode);
        if (mode == 0) return 0;
        if (mode == 1) return $urandom_range(0, 15);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    endfunction

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready = 1'b0;
            rx_hold--;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_segment(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
            rx_hold = draw_wait(rx_mode);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // all tasks start and end at a falling edge
    task automatic cfg_write(t_cfg_index idx, logic [31:0] d);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, d);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_step(bit restart);
        int gap;
        gap = draw_wait(tx_mode);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{(IN_TDATA_BITS-1){1'b0}}, restart};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_step(restart);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (sb.segments_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic setup_walk(logic [31:0] zm, logic [15:0] x, logic [15:0] y,
                              logic [31:0] ph, logic [23:0] lim);
        wait_drained();
        cfg_write(CFG_ZOOM, zm);
        cfg_write(CFG_CENTRE_X, {16'($urandom_range(0, 65535)), x});
        cfg_write(CFG_CENTRE_Y, {16'($urandom_range(0, 65535)), y});
        cfg_write(CFG_PHASE_STEP, ph);
        cfg_write(CFG_ITER_LIMIT, {8'($urandom_range(0, 255)), lim});
    endtask

    function automatic logic [31:0] pick_zoom();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'hFFFF_FFFF;
            2: return 32'd0;
            3: return 32'd65536;
            default: return $urandom_range(32'h100, 32'h40000);
        endcase
    endfunction

    function automatic logic [15:0] pick_centre();
        case ($urandom_range(0, 4))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [23:0] pick_limit();
        case ($urandom_range(0, 7))
            0: return 24'hFF_FFFF;
            1: return 24'd0;
            2: return 24'($urandom_range(1, 24'hFF_FFFF));
            default: return 24'($urandom_range(1, 150));
        endcase
    endfunction

    initial begin
        int lim;
        int walk_len;
        sb            = new();
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_ZOOM;
        i_cfg_data    = '0;
        tx_mode       = 0;
        rx_mode       = 0;
        rx_hold       = 0;
        quiet         = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values, back-to-back, with a restart mid-walk
        for (int i = 0; i < 8; i++) begin
            send_step(FIRST_RESTARTS[i]);
        end
        // saturating zoom and centres, one-segment walk
        setup_walk(32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF, 24'd1);
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b1);
        send_step(1'b0);
        // zero zoom and zero limit
        setup_walk(32'd0, 16'h8000, 16'h7FFF, 32'd660174260, 24'd0);
        send_step(1'b0);
        send_step(1'b1);
        send_step(1'b0);
        // small zoom for truncation toward zero, then limit lowered below count
        setup_walk(32'h0000_1234, 16'h0000, 16'h0000, 32'd660174260, 24'd3);
        repeat (2) begin
            send_step(1'b1);
            send_step(1'b0);
            send_step(1'b0);
            send_step(1'b0);
        end
        wait_drained();
        cfg_write(CFG_ITER_LIMIT, 32'd2);
        send_step(1'b0);
        send_step(1'b1);

        for (int phase = 0; phase < 10; phase++) begin
            setup_walk(pick_zoom(), pick_centre(), pick_centre(),
                       ($urandom_range(0, 2) == 0) ? 32'd660174260 : $urandom(),
                       pick_limit());
            tx_mode  = $urandom_range(0, 2);
            rx_mode  = $urandom_range(0, 2);
            lim      = int'(sb.iter_limit);
            walk_len = (lim < 150) ? lim + 3 : 150;
            send_step($urandom_range(0, 3) != 0);
            for (int n = 0; n < 112; n++) begin
                if ($urandom_range(0, 99) == 0) wait_drained();
                send_step($urandom_range(0, walk_len) == 0);
            end
        end

        wait_drained();
        repeat (END_WAIT) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[curlicue_walk_segment_generator.f]
rtl/cwsg_pkg.sv
rtl/cwsg_heading.sv
rtl/cwsg_sine_rom.sv
rtl/cwsg_position.sv
rtl/cwsg_screen_map.sv
rtl/curlicue_walk_segment_generator.sv
tb/tb_top.sv
